// ===== rtl/ptwa_pkg.sv =====
// shared types and constants of the peer table with aging
`default_nettype none

package ptwa_pkg;

    // table size and derived widths
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // apb register map
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_MAX_AGE    = 2'd0;
    localparam logic [1:0] REG_MASTER_CAP = 2'd1;
    localparam logic [1:0] REG_LOCAL_CAPS = 2'd2;

    localparam logic [7:0] MAX_AGE_RST    = 8'd10;
    localparam logic [7:0] MASTER_CAP_RST = 8'd1;
    localparam logic [7:0] LOCAL_CAPS_RST = 8'd0;

    // opcodes of an input transaction
    localparam logic OP_ANNOUNCE = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    typedef enum logic [1:0] {
        ST_REFRESH = 2'd0,
        ST_ADDED   = 2'd1,
        ST_FULL    = 2'd2,
        ST_TICK    = 2'd3
    } t_status;

    typedef struct packed {
        logic [63:0] addr;
        logic [7:0]  caps;
        logic [7:0]  age;
    } t_entry;

    typedef struct packed {
        logic [7:0] max_age;
        logic [7:0] master_mask;
        logic [7:0] local_caps;
    } t_cfg;

    typedef struct packed {
        t_status    status;
        logic [3:0] slot;
        logic [4:0] freed_count;
        logic [4:0] live_count;
        logic       multi_master;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/ptwa_ram.sv =====
// simple dual port ram, one write and one registered read per cycle
`default_nettype none

module ptwa_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 80,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/ptwa_cfg.sv =====
// apb configuration registers
`default_nettype none

module ptwa_cfg
    import ptwa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_age     <= MAX_AGE_RST;
            r_cfg.master_mask <= MASTER_CAP_RST;
            r_cfg.local_caps  <= LOCAL_CAPS_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_MAX_AGE:    r_cfg.max_age     <= pwdata[7:0];
                REG_MASTER_CAP: r_cfg.master_mask <= pwdata[7:0];
                REG_LOCAL_CAPS: r_cfg.local_caps  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MAX_AGE:    prdata = {24'd0, r_cfg.max_age};
            REG_MASTER_CAP: prdata = {24'd0, r_cfg.master_mask};
            REG_LOCAL_CAPS: prdata = {24'd0, r_cfg.local_caps};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ptwa_scan.sv =====
// scan sequencer: walks the entry ram, read-modify-write per transaction
`default_nettype none

module ptwa_scan
    import ptwa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_opcode,
    input  wire logic [31:0]      i_addr_low,
    input  wire logic [31:0]      i_addr_high,
    input  wire logic [7:0]       i_peer_caps,
    output t_result               o_res,
    output logic                  o_res_valid,
    input  wire logic             i_res_take,
    output logic      [IDX_W-1:0] o_rd_addr,
    input  wire t_entry           i_rd_data,
    output logic                  o_wr_en,
    output logic      [IDX_W-1:0] o_wr_addr,
    output t_entry                o_wr_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state             r_state;
    logic               r_opcode;
    logic [63:0]        r_key;
    logic [7:0]         r_caps;
    logic [CNT_W-1:0]   r_issue;
    logic               r_chk;
    logic [IDX_W-1:0]   r_chk_idx;
    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]   r_live;
    logic               r_hit_found;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [7:0]         r_hit_old_caps;
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_idx;
    logic [CNT_W-1:0]   r_mcount;
    logic [CNT_W-1:0]   r_freed;
    t_result            r_res;

    t_entry           w_ent;
    logic             w_live_k;
    logic             w_m_old;
    logic             w_expire;
    logic [7:0]       w_new_age;
    logic             w_match;
    logic             w_last;
    logic             w_issue_more;
    logic [IDX_W-1:0] w_tgt_idx;
    logic             w_tgt_ok;
    logic [CNT_W-1:0] w_live_new;
    logic [CNT_W:0]   w_mtot;
    t_status          w_status;
    logic [31:0]      w_slot_wide;
    logic [31:0]      w_live_wide;
    logic [31:0]      w_freed_wide;

    function automatic logic is_master(input logic [7:0] caps, input logic [7:0] mask);
        is_master = |(caps & mask);
    endfunction

    assign o_stall     = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
    assign o_rd_addr   = r_issue[IDX_W-1:0];

    // free entries always read as all zero
    assign w_live_k  = r_valid[r_chk_idx];
    assign w_ent     = w_live_k ? i_rd_data : '0;
    assign w_m_old   = is_master(w_ent.caps, i_cfg.master_mask);
    assign w_expire  = w_live_k && (w_ent.age > i_cfg.max_age);
    assign w_new_age = (w_ent.age == 8'hFF) ? w_ent.age : w_ent.age + 8'd1;
    assign w_match   = (w_ent.addr == r_key);
    assign w_last    = r_chk && (r_chk_idx == IDX_W'(ENTRIES - 1));
    assign w_issue_more = (r_issue != CNT_W'(ENTRIES));

    assign w_tgt_idx = r_hit_found ? r_hit_idx : r_free_idx;
    assign w_tgt_ok  = r_hit_found || r_free_found;

    // memory write port: aging writeback during the scan, fill after it
    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_addr = r_chk_idx;
        o_wr_data = '0;
        if (r_state == S_SCAN && r_chk && r_opcode == OP_TICK && w_live_k) begin
            o_wr_en = 1'b1;
            if (!w_expire) begin
                o_wr_data.addr = w_ent.addr;
                o_wr_data.caps = w_ent.caps;
                o_wr_data.age  = w_new_age;
            end
        end else if (r_state == S_WRITE && r_opcode == OP_ANNOUNCE && w_tgt_ok) begin
            o_wr_en        = 1'b1;
            o_wr_addr      = w_tgt_idx;
            o_wr_data.addr = r_key;
            o_wr_data.caps = r_caps;
            o_wr_data.age  = 8'd0;
        end
    end

    // result of the finished scan
    always_comb begin
        w_mtot = {1'b0, r_mcount}
               + (CNT_W+1)'(is_master(i_cfg.local_caps, i_cfg.master_mask));
        w_live_new = r_live;
        w_status   = ST_TICK;
        if (r_opcode == OP_TICK) begin
            w_live_new = r_live - r_freed;
        end else if (r_hit_found) begin
            w_status   = ST_REFRESH;
            w_live_new = r_live + CNT_W'(!r_valid[r_hit_idx]);
            w_mtot     = w_mtot + (CNT_W+1)'(is_master(r_caps, i_cfg.master_mask))
                       - (CNT_W+1)'(is_master(r_hit_old_caps, i_cfg.master_mask));
        end else if (r_free_found) begin
            w_status   = ST_ADDED;
            w_live_new = r_live + CNT_W'(1);
            w_mtot     = w_mtot + (CNT_W+1)'(is_master(r_caps, i_cfg.master_mask));
        end else begin
            w_status   = ST_FULL;
        end
        w_slot_wide  = (r_opcode == OP_ANNOUNCE && w_tgt_ok) ? 32'(w_tgt_idx) : 32'd0;
        w_live_wide  = 32'(w_live_new);
        w_freed_wide = (r_opcode == OP_TICK) ? 32'(r_freed) : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_live  <= '0;
            r_chk   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_opcode     <= i_opcode;
                        r_key        <= {i_addr_high, i_addr_low};
                        r_caps       <= i_peer_caps;
                        r_issue      <= '0;
                        r_chk        <= 1'b0;
                        r_hit_found  <= 1'b0;
                        r_free_found <= 1'b0;
                        r_mcount     <= '0;
                        r_freed      <= '0;
                        r_state      <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_issue_more) begin
                        r_issue <= r_issue + CNT_W'(1);
                    end
                    r_chk     <= w_issue_more;
                    r_chk_idx <= r_issue[IDX_W-1:0];
                    if (r_chk) begin
                        if (r_opcode == OP_TICK) begin
                            // master count over the caps left after aging
                            r_mcount <= r_mcount + CNT_W'(w_m_old && !w_expire);
                            if (w_expire) begin
                                r_valid[r_chk_idx] <= 1'b0;
                                r_freed <= r_freed + CNT_W'(1);
                            end
                        end else begin
                            r_mcount <= r_mcount + CNT_W'(w_m_old);
                            if (!r_hit_found) begin
                                if (!w_live_k && !r_free_found) begin
                                    r_free_found <= 1'b1;
                                    r_free_idx   <= r_chk_idx;
                                end
                                if (w_match) begin
                                    r_hit_found    <= 1'b1;
                                    r_hit_idx      <= r_chk_idx;
                                    r_hit_old_caps <= w_ent.caps;
                                end
                            end
                        end
                    end
                    if (w_last) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (r_opcode == OP_ANNOUNCE && w_tgt_ok) begin
                        r_valid[w_tgt_idx] <= 1'b1;
                    end
                    r_live             <= w_live_new;
                    r_res.status       <= w_status;
                    r_res.slot         <= w_slot_wide[3:0];
                    r_res.freed_count  <= w_freed_wide[4:0];
                    r_res.live_count   <= w_live_wide[4:0];
                    r_res.multi_master <= (w_mtot > (CNT_W+1)'(1));
                    r_state            <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/peer_table_with_aging.sv =====
// top level of the peer table with aging
`default_nettype none

// Peer table with aging. Holds ENTRIES remote peers (address, capability byte,
// age) in a dual port ram, with the in-use bits in flip-flops so that reset
// frees the whole table at once and no clearing pass is needed. Each input
// transaction is an announce (opcode 0) or an aging tick (opcode 1) and gives
// exactly one result transaction. Every transaction walks the ram once, one
// entry read per cycle from the registered read port: an announce looks for
// the first entry with its address and the lowest free entry, then writes the
// chosen entry; a tick ages or frees each live entry as it streams past. The
// master-capable count is gathered on the same walk. The next transaction is
// taken once the result has moved into the output register, where it may
// still sit while the next walk runs, so a walk never starts before the last
// one is over. Registers on the apb port (max_age, master_cap_mask,
// local_caps) are to be written by the user only while the block is idle;
// the block itself does not enforce this.
module peer_table_with_aging
    import ptwa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // apb configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    // input channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_opcode,
    input  wire logic [31:0]        i_addr_low,
    input  wire logic [31:0]        i_addr_high,
    input  wire logic [7:0]         i_peer_caps,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic      [1:0]         o_status,
    output logic      [3:0]         o_slot,
    output logic      [4:0]         o_freed_count,
    output logic      [4:0]         o_live_count,
    output logic                    o_multi_master
);

    t_cfg             w_cfg;
    t_result          w_res;
    logic             w_res_valid;
    logic             w_res_take;
    logic [IDX_W-1:0] w_rd_addr;
    logic [IDX_W-1:0] w_wr_addr;
    logic             w_wr_en;
    t_entry           w_wr_data;
    t_entry           w_rd_data;

    t_result          r_out;
    logic             r_out_valid;

    ptwa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ptwa_ram #(
        .DEPTH (ENTRIES),
        .WIDTH ($bits(t_entry))
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    ptwa_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_addr_low  (i_addr_low),
        .i_addr_high (i_addr_high),
        .i_peer_caps (i_peer_caps),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_res_take),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

    // output register: a finished result moves in when the slot is empty
    // or its transaction completes in this cycle
    assign w_res_take = w_res_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_slot         = r_out.slot;
    assign o_freed_count  = r_out.freed_count;
    assign o_live_count   = r_out.live_count;
    assign o_multi_master = r_out.multi_master;

endmodule

`default_nettype wire

// ===== rtl/ptwa_checker.sv =====
// port level checks on the peer table with aging, bound to the top level
`default_nettype none

module ptwa_checker
    import ptwa_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_stall,
    input wire logic       o_valid,
    input wire logic [1:0] o_status,
    input wire logic [3:0] o_slot,
    input wire logic [4:0] o_freed_count,
    input wire logic [4:0] o_live_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_slot)
            && $stable(o_freed_count) && $stable(o_live_count))
        else $error("stalled result changed");

    // a tick names no slot
    a_tick_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_TICK |-> o_slot == 4'd0)
        else $error("tick result carries a slot");

    // only a tick frees entries
    a_ann_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_TICK |-> o_freed_count == 5'd0)
        else $error("announce result reports freed entries");

    // a dropped announce means every entry is in use
    a_full_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_live_count == 5'(ENTRIES))
        else $error("announce dropped while the table has room");

endmodule

bind peer_table_with_aging ptwa_checker u_checker (.*);

`default_nettype wire
